// ===== hdl/ctip_pkg.sv =====
// Package for the cooling table interpolator: shared types, codes and constants.
// Depends on nothing; the front, back, top level and checkers refer to it by scoped names.
package ctip_pkg;

	localparam int unsigned FRAC_BITS = 12;
	localparam int unsigned ROW_W     = 32;
	localparam int unsigned RATE_W    = 40;
	localparam int unsigned LRATE_W   = 49;
	localparam int unsigned NUM_W     = 82;
	localparam int unsigned DIV_STEPS = 40;
	localparam int unsigned PPROD_W   = 57;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] ST_INTERP     = 2'd0;
	localparam logic [1:0] ST_BELOW_CUT  = 2'd1;
	localparam logic [1:0] ST_CLAMP_LOW  = 2'd2;
	localparam logic [1:0] ST_CLAMP_HIGH = 2'd3;

	localparam logic CFG_ENTRY_COUNT = 1'b0;
	localparam logic CFG_MIN_TEMP    = 1'b1;

	// Classified item as held in the queue between front and back.
	typedef struct packed {
		logic        is_query;
		logic        wr_ok;
		logic [9:0]  row_index;
		logic [31:0] row_temperature;
		logic [31:0] row_rate_primordial;
		logic [31:0] row_rate_metal;
		logic [31:0] temperature;
		logic [15:0] metallicity;
	} item_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_CK_HI,
		BK_CK_LO,
		BK_SRCH,
		BK_CHK,
		BK_ML,
		BK_MH,
		BK_MP,
		BK_DV,
		BK_OUT
	} back_state_t;

endpackage

// ===== hdl/ctip_if.sv =====
// Handshake channels of the cooling table interpolator: input items and results.
// Depends on nothing; payload widths are the fixed field widths of the block.
interface ctip_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [9:0]  row_index;
	logic [31:0] row_temperature;
	logic [31:0] row_rate_primordial;
	logic [31:0] row_rate_metal;
	logic [31:0] temperature;
	logic [15:0] metallicity;

	modport source (output valid, opcode, row_index, row_temperature, row_rate_primordial,
		row_rate_metal, temperature, metallicity, input ready);
	modport sink (input valid, opcode, row_index, row_temperature, row_rate_primordial,
		row_rate_metal, temperature, metallicity, output ready);
endinterface

interface ctip_out_if;
	logic        valid;
	logic        ready;
	logic [39:0] cooling_rate;
	logic [1:0]  range_status;

	modport source (output valid, cooling_rate, range_status, input ready);
	modport sink (input valid, cooling_rate, range_status, output ready);
endinterface

// ===== hdl/ctip_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
// Depends on nothing.
module ctip_ram #(
	parameter int unsigned WIDTH = 96,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hdl/ctip_front.sv =====
// Front part: accepts items, classifies them and holds them in a two-entry queue.
// Depends on ctip_pkg and the ctip_in_if interface.
module ctip_front #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	ctip_in_if.sink          item_in,
	output logic             head_valid,
	output ctip_pkg::item_t  head,
	input  logic             pop
);
	ctip_pkg::item_t slot_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	ctip_pkg::item_t cls;

	assign item_in.ready = (count_q != 2'd2);
	assign push          = item_in.valid && item_in.ready;
	assign head_valid    = (count_q != 2'd0);
	assign head          = slot_q[rd_ptr_q];

	// Classify the item: query or write, and whether the write lands inside the table.
	always_comb begin
		cls.is_query            = (item_in.opcode == ctip_pkg::OP_QUERY);
		cls.wr_ok               = (32'(item_in.row_index) < 32'(TABLE_DEPTH));
		cls.row_index           = item_in.row_index;
		cls.row_temperature     = item_in.row_temperature;
		cls.row_rate_primordial = item_in.row_rate_primordial;
		cls.row_rate_metal      = item_in.row_rate_metal;
		cls.temperature         = item_in.temperature;
		cls.metallicity         = item_in.metallicity;
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== hdl/ctip_back.sv =====
// Back part: table writes, binary search, interpolation and the result register.
// Depends on ctip_pkg, ctip_ram and the ctip_out_if interface.
module ctip_back #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  ctip_pkg::item_t head,
	output logic            pop,
	input  logic [10:0]     entry_count,
	input  logic [31:0]     min_temperature,
	ctip_out_if.source      result_out
);
	localparam int unsigned AW = $clog2(TABLE_DEPTH);

	ctip_pkg::back_state_t state_q, state_n;

	logic [AW-1:0]  rd_addr;
	logic           we;
	logic [95:0]    rdata;
	logic [31:0]    d_t;
	logic [31:0]    d_p;
	logic [31:0]    d_m;

	logic [31:0]    t_q;
	logic [15:0]    z_q;
	logic [AW-1:0]  lo_q, hi_q;
	logic [31:0]    lo_t_q, lo_p_q, lo_m_q;
	logic [31:0]    hi_t_q, hi_p_q, hi_m_q;
	logic [1:0]     status_q;
	logic           interp_q;
	logic [31:0]    dt_q, dhi_q, dlo_q;
	logic [48:0]    llo_q, lhi_q;
	logic [2:0]     step_q;
	logic [5:0]     dcnt_q;
	logic [56:0]    prod_q;
	logic           sh_q;
	logic [81:0]    acc_q;
	logic [43:0]    rem_q;
	logic [39:0]    quo_q;
	logic [39:0]    res_rate_q;

	logic           out_valid_q;
	logic [39:0]    out_rate_q;
	logic [1:0]     out_status_q;

	logic [AW-1:0]  n_m1;
	logic [AW-1:0]  mid_c, nlo, nhi, nmid;
	logic           go_hi, gap_c, ngap, below_c, out_free, bracket_ok;
	logic [31:0]    sel_p, sel_m;
	logic [48:0]    l_c;
	logic [24:0]    mul_a;
	logic [31:0]    mul_b;
	logic [81:0]    acc_n;
	logic [43:0]    divisor;
	logic [44:0]    trial;
	logic           ge;

	assign d_t = rdata[95:64];
	assign d_p = rdata[63:32];
	assign d_m = rdata[31:0];

	ctip_ram #(.WIDTH(96), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (AW'(head.row_index)),
		.wdata ({head.row_temperature, head.row_rate_primordial, head.row_rate_metal}),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// Last row used by the search, with the entry count clamped to the table.
	always_comb begin
		if (entry_count < 11'd2) begin
			n_m1 = AW'(1);
		end else if (32'(entry_count) > 32'(TABLE_DEPTH)) begin
			n_m1 = AW'(TABLE_DEPTH - 1);
		end else begin
			n_m1 = AW'(entry_count - 11'd1);
		end
	end

	// Search step: midpoint of the current bracket and the bracket after this probe.
	always_comb begin
		mid_c = AW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
		gap_c = ({1'b0, hi_q} > ({1'b0, lo_q} + (AW+1)'(1)));
		go_hi = (t_q <= d_t);
		nlo   = go_hi ? lo_q : mid_c;
		nhi   = go_hi ? mid_c : hi_q;
		nmid  = AW'(({1'b0, nlo} + {1'b0, nhi}) >> 1);
		ngap  = ({1'b0, nhi} > ({1'b0, nlo} + (AW+1)'(1)));
	end

	assign below_c    = (head.temperature < min_temperature);
	assign out_free   = !out_valid_q || result_out.ready;
	assign bracket_ok = (lo_t_q < hi_t_q) && (lo_t_q <= t_q) && (t_q <= hi_t_q);

	// Row rate in Q.12: primordial plus metallicity times metal.
	always_comb begin
		sel_p = (state_q == ctip_pkg::BK_MH) ? hi_p_q : lo_p_q;
		sel_m = (state_q == ctip_pkg::BK_MH) ? hi_m_q : lo_m_q;
		l_c   = 49'({sel_p, 12'd0}) + 49'(48'(z_q) * 48'(sel_m));
	end

	// Partial products of the numerator, one per step, in halves of each row rate.
	always_comb begin
		case (step_q[1:0])
			2'd0:    mul_a = {1'b0, llo_q[23:0]};
			2'd1:    mul_a = llo_q[48:24];
			2'd2:    mul_a = {1'b0, lhi_q[23:0]};
			default: mul_a = lhi_q[48:24];
		endcase
		mul_b = step_q[1] ? dlo_q : dhi_q;
		acc_n = acc_q + (sh_q ? (82'(prod_q) << 24) : 82'(prod_q));
	end

	// Restoring division step.
	always_comb begin
		divisor = {dt_q, 12'd0};
		trial   = {rem_q, quo_q[39]};
		ge      = (trial >= {1'b0, divisor});
	end

	// Next state.
	always_comb begin
		state_n = state_q;
		case (state_q)
			ctip_pkg::BK_IDLE: begin
				if (head_valid && head.is_query) begin
					state_n = below_c ? ctip_pkg::BK_OUT : ctip_pkg::BK_CK_HI;
				end
			end
			ctip_pkg::BK_CK_HI: begin
				state_n = (t_q > d_t) ? ctip_pkg::BK_ML : ctip_pkg::BK_CK_LO;
			end
			ctip_pkg::BK_CK_LO: begin
				if (t_q < d_t) begin
					state_n = ctip_pkg::BK_ML;
				end else begin
					state_n = gap_c ? ctip_pkg::BK_SRCH : ctip_pkg::BK_CHK;
				end
			end
			ctip_pkg::BK_SRCH: begin
				state_n = ngap ? ctip_pkg::BK_SRCH : ctip_pkg::BK_CHK;
			end
			ctip_pkg::BK_CHK: state_n = ctip_pkg::BK_ML;
			ctip_pkg::BK_ML: state_n = interp_q ? ctip_pkg::BK_MH : ctip_pkg::BK_OUT;
			ctip_pkg::BK_MH: state_n = ctip_pkg::BK_MP;
			ctip_pkg::BK_MP: begin
				if (step_q == 3'd4) begin
					state_n = ctip_pkg::BK_DV;
				end
			end
			ctip_pkg::BK_DV: begin
				if (dcnt_q == 6'(ctip_pkg::DIV_STEPS - 1)) begin
					state_n = ctip_pkg::BK_OUT;
				end
			end
			ctip_pkg::BK_OUT: begin
				if (out_free) begin
					state_n = ctip_pkg::BK_IDLE;
				end
			end
			default: state_n = ctip_pkg::BK_IDLE;
		endcase
	end

	// Control outputs: queue pop, table write and read address.
	always_comb begin
		pop     = 1'b0;
		we      = 1'b0;
		rd_addr = '0;
		case (state_q)
			ctip_pkg::BK_IDLE: begin
				pop     = head_valid;
				we      = head_valid && !head.is_query && head.wr_ok;
				rd_addr = n_m1;
			end
			ctip_pkg::BK_CK_HI: rd_addr = '0;
			ctip_pkg::BK_CK_LO: rd_addr = mid_c;
			ctip_pkg::BK_SRCH:  rd_addr = nmid;
			default:            rd_addr = '0;
		endcase
	end

	// State register and result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ctip_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == ctip_pkg::BK_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ctip_pkg::BK_IDLE: begin
				t_q        <= head.temperature;
				z_q        <= head.metallicity;
				lo_q       <= '0;
				hi_q       <= n_m1;
				status_q   <= ctip_pkg::ST_BELOW_CUT;
				interp_q   <= 1'b0;
				res_rate_q <= '0;
			end
			ctip_pkg::BK_CK_HI: begin
				if (t_q > d_t) begin
					lo_t_q   <= d_t;
					lo_p_q   <= d_p;
					lo_m_q   <= d_m;
					status_q <= ctip_pkg::ST_CLAMP_HIGH;
				end else begin
					hi_t_q <= d_t;
					hi_p_q <= d_p;
					hi_m_q <= d_m;
				end
			end
			ctip_pkg::BK_CK_LO: begin
				lo_t_q   <= d_t;
				lo_p_q   <= d_p;
				lo_m_q   <= d_m;
				status_q <= (t_q < d_t) ? ctip_pkg::ST_CLAMP_LOW : ctip_pkg::ST_INTERP;
			end
			ctip_pkg::BK_SRCH: begin
				lo_q <= nlo;
				hi_q <= nhi;
				if (go_hi) begin
					hi_t_q <= d_t;
					hi_p_q <= d_p;
					hi_m_q <= d_m;
				end else begin
					lo_t_q <= d_t;
					lo_p_q <= d_p;
					lo_m_q <= d_m;
				end
			end
			ctip_pkg::BK_CHK: begin
				interp_q <= bracket_ok;
				dt_q     <= hi_t_q - lo_t_q;
				dhi_q    <= hi_t_q - t_q;
				dlo_q    <= t_q - lo_t_q;
			end
			ctip_pkg::BK_ML: begin
				llo_q      <= l_c;
				res_rate_q <= 40'(l_c >> ctip_pkg::FRAC_BITS);
			end
			ctip_pkg::BK_MH: begin
				lhi_q  <= l_c;
				step_q <= 3'd0;
				acc_q  <= '0;
				sh_q   <= 1'b0;
			end
			ctip_pkg::BK_MP: begin
				prod_q <= 57'(mul_a) * 57'(mul_b);
				sh_q   <= step_q[0];
				step_q <= step_q + 3'd1;
				if (step_q != 3'd0) begin
					acc_q <= acc_n;
				end
				rem_q  <= 44'(acc_n[81:40]);
				quo_q  <= acc_n[39:0];
				dcnt_q <= '0;
			end
			ctip_pkg::BK_DV: begin
				rem_q      <= ge ? 44'(trial - {1'b0, divisor}) : trial[43:0];
				quo_q      <= {quo_q[38:0], ge};
				dcnt_q     <= dcnt_q + 6'd1;
				res_rate_q <= {quo_q[38:0], ge};
			end
			default: begin
			end
		endcase
		if (state_q == ctip_pkg::BK_OUT && out_free) begin
			out_rate_q   <= res_rate_q;
			out_status_q <= status_q;
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.cooling_rate = out_rate_q;
	assign result_out.range_status = out_status_q;
endmodule

// ===== hdl/cooling_table_interpolator_core.sv =====
// Top level of the cooling table interpolator: configuration registers, front and back.
// Depends on ctip_pkg, ctip_if, ctip_front and ctip_back.
//
//  Channel     Dir   Handshake        Carries
//  item_in     in    valid/ready      table row writes and rate queries
//  result_out  out   valid/ready      cooling_rate, range_status (one per query)
//  cfg         in    cfg_we only      entry_count (index 0), min_temperature (index 1)
//
// A write item goes to the table as the back part pops it. A query below the cutoff goes
// straight to the result register; other queries check the last row and, if needed, the
// first row, take the rate of a clamping row, or run the binary search, one table read per
// search step, the partial products and the divider, one quotient bit per cycle. The queue
// accepts items while the back part works or a result waits, until both entries are full.
// Reset clears control state and the cutoff and sets entry_count to 2; the table is undefined until written.
module cooling_table_interpolator_core #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	ctip_in_if.sink     item_in,
	ctip_out_if.source  result_out,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	logic [10:0]     entry_count_q;
	logic [31:0]     min_temperature_q;
	logic            head_valid;
	ctip_pkg::item_t head;
	logic            pop;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q     <= 11'd2;
			min_temperature_q <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				ctip_pkg::CFG_ENTRY_COUNT: entry_count_q     <= cfg_data[10:0];
				ctip_pkg::CFG_MIN_TEMP:    min_temperature_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ctip_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_in),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	ctip_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_valid      (head_valid),
		.head            (head),
		.pop             (pop),
		.entry_count     (entry_count_q),
		.min_temperature (min_temperature_q),
		.result_out      (result_out)
	);
endmodule

// ===== hdl/ctip_checker.sv =====
// Port-level checks on the cooling table interpolator, bound to the top level.
// Depends on ctip_pkg and cooling_table_interpolator_core.
module ctip_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [39:0] cooling_rate,
	input logic [1:0]  range_status
);
	// A waiting result item stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	// A result below the cutoff carries a zero rate.
	a_cut: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_status == ctip_pkg::ST_BELOW_CUT |-> cooling_rate == 40'd0)
		else $error("below cutoff result with nonzero rate");

	// Any rate is at most the largest row rate shifted down by the 12 fraction bits, so the top three bits stay clear.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cooling_rate[39:37] == 3'd0)
		else $error("cooling rate above the largest possible row rate");
endmodule

bind cooling_table_interpolator_core ctip_checker u_ctip_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (result_out.valid),
	.out_ready    (result_out.ready),
	.cooling_rate (result_out.cooling_rate),
	.range_status (result_out.range_status)
);

// ===== dv/cooling_table_interpolator_checker.sv =====
// Checker for the cooling table interpolator: watches both channels and the register port,
// predicts each cooling rate from its own table copy and compares. Depends on ctip_pkg, ctip_if.
`timescale 1ns / 100ps
module cooling_table_interpolator_checker (
	input  logic        clk,
	input  logic        arst_n,
	ctip_in_if          item_ch,
	ctip_out_if         rate_ch,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output int unsigned fail_count,
	output int unsigned pending_count
);
	localparam int unsigned DEPTH = 1024;
	localparam logic [39:0] RATE_SAT = 40'hFF_FFFF_FFFF;

	typedef struct packed {
		logic [39:0] cooling_rate;
		logic [1:0]  range_status;
	} rate_result_t;

	logic [31:0]  temp_tab [DEPTH];
	logic [31:0]  prim_tab [DEPTH];
	logic [31:0]  metal_tab [DEPTH];
	logic [10:0]  entry_count;
	logic [31:0]  min_temp;
	rate_result_t expected_rates [$];

	// Row rate in Q.12: primordial shifted up plus metallicity times metal.
	function automatic logic [63:0] row_rate(input int unsigned k, input logic [15:0] z);
		return ({32'd0, prim_tab[k]} << ctip_pkg::FRAC_BITS) + 64'(z) * 64'(metal_tab[k]);
	endfunction

	// Cooling rate and range status of one query against the current table.
	function automatic rate_result_t predict_rate(input logic [31:0] t, input logic [15:0] z);
		rate_result_t r;
		int unsigned  n, lo, hi, mid;
		logic [31:0]  tlo, thi;
		logic [127:0] num, den, quo;
		n = entry_count;
		if (n < 2) n = 2;
		if (n > DEPTH) n = DEPTH;
		lo = 0;
		hi = n - 1;
		if (t < min_temp) begin
			r.cooling_rate = '0;
			r.range_status = ctip_pkg::ST_BELOW_CUT;
		end else if (t > temp_tab[hi]) begin
			r.cooling_rate = 40'(row_rate(hi, z) >> ctip_pkg::FRAC_BITS);
			r.range_status = ctip_pkg::ST_CLAMP_HIGH;
		end else if (t < temp_tab[lo]) begin
			r.cooling_rate = 40'(row_rate(lo, z) >> ctip_pkg::FRAC_BITS);
			r.range_status = ctip_pkg::ST_CLAMP_LOW;
		end else begin
			while (hi - lo > 1) begin
				mid = (lo + hi) >> 1;
				if (t <= temp_tab[mid]) hi = mid;
				else lo = mid;
			end
			tlo = temp_tab[lo];
			thi = temp_tab[hi];
			r.range_status = ctip_pkg::ST_INTERP;
			if (tlo < thi && tlo <= t && t <= thi) begin
				num = 128'(row_rate(lo, z)) * 128'(thi - t) + 128'(row_rate(hi, z)) * 128'(t - tlo);
				den = 128'(thi - tlo) << ctip_pkg::FRAC_BITS;
				quo = num / den;
				r.cooling_rate = (quo > 128'(RATE_SAT)) ? RATE_SAT : quo[39:0];
			end else begin
				// Bracket not strictly increasing: the lower row's rate stands.
				r.cooling_rate = 40'(row_rate(lo, z) >> ctip_pkg::FRAC_BITS);
			end
		end
		return r;
	endfunction

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rate_result_t want;
		if (!arst_n) begin
			entry_count = 11'd2;
			min_temp = '0;
			expected_rates.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == ctip_pkg::CFG_ENTRY_COUNT) entry_count = cfg_data[10:0];
				else min_temp = cfg_data;
			end
			// Results are compared before this edge's item is added.
			if (rate_ch.valid && rate_ch.ready) begin
				if (expected_rates.size() == 0) begin
					report("result item with no query waiting");
				end else begin
					want = expected_rates.pop_front();
					if (rate_ch.cooling_rate !== want.cooling_rate)
						report($sformatf("cooling_rate %h, expected %h",
							rate_ch.cooling_rate, want.cooling_rate));
					if (rate_ch.range_status !== want.range_status)
						report($sformatf("range_status %0d, expected %0d",
							rate_ch.range_status, want.range_status));
				end
			end
			if (item_ch.valid && item_ch.ready) begin
				if (item_ch.opcode == ctip_pkg::OP_WRITE) begin
					temp_tab[item_ch.row_index] = item_ch.row_temperature;
					prim_tab[item_ch.row_index] = item_ch.row_rate_primordial;
					metal_tab[item_ch.row_index] = item_ch.row_rate_metal;
				end else begin
					expected_rates.push_back(predict_rate(item_ch.temperature,
						item_ch.metallicity));
				end
			end
		end
		pending_count = expected_rates.size();
	end
endmodule

// ===== dv/cooling_table_interpolator_core_tb.sv =====
// Testbench top for the cooling table interpolator: clock, reset, item and register stimulus.
// Depends on ctip_pkg, ctip_if, the block and cooling_table_interpolator_checker.
`timescale 1ns / 100ps
module cooling_table_interpolator_core_tb;
	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_data;
	int unsigned fail_count;
	int unsigned pending_count;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned items_sent;
	int unsigned live_rows;
	logic [31:0] row_temp [1024];

	ctip_in_if  item_in ();
	ctip_out_if result_out ();

	cooling_table_interpolator_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_in),
		.result_out (result_out),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	cooling_table_interpolator_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_ch       (item_in),
		.rate_ch       (result_out),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// The receiver stalls at random by the current idling share.
	always @(negedge clk) begin
		result_out.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Idling shares move through the three patterns as items go out.
	always @(negedge clk) begin
		if (items_sent < 580) begin
			send_idle_pct <= 34;
			recv_idle_pct <= 61;
		end else if (items_sent < 1160) begin
			send_idle_pct <= 61;
			recv_idle_pct <= 34;
		end else begin
			send_idle_pct <= 0;
			recv_idle_pct <= 0;
		end
	end

	initial begin
		#40ms;
		$display("Simulation FAILED");
		$finish;
	end

	// Presents one item from a falling edge and holds it until accepted.
	task automatic send_item(input logic op, input logic [9:0] idx, input logic [31:0] rt,
		input logic [31:0] rp, input logic [31:0] rm, input logic [31:0] t,
		input logic [15:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			item_in.valid <= 1'b0;
			@(negedge clk);
		end
		item_in.valid               <= 1'b1;
		item_in.opcode              <= op;
		item_in.row_index           <= idx;
		item_in.row_temperature     <= rt;
		item_in.row_rate_primordial <= rp;
		item_in.row_rate_metal      <= rm;
		item_in.temperature         <= t;
		item_in.metallicity         <= z;
		if (op == ctip_pkg::OP_WRITE) row_temp[idx] = rt;
		do @(posedge clk); while (!item_in.ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_row(input logic [9:0] idx, input logic [31:0] rt,
		input logic [31:0] rp, input logic [31:0] rm);
		send_item(ctip_pkg::OP_WRITE, idx, rt, rp, rm, $urandom, 16'($urandom));
	endtask

	task automatic query(input logic [31:0] t, input logic [15:0] z);
		send_item(ctip_pkg::OP_QUERY, 10'($urandom), $urandom, $urandom, $urandom, t, z);
	endtask

	// Drains the block, then writes both registers while it is idle.
	task automatic set_registers(input logic [31:0] count, input logic [31:0] cutoff);
		item_in.valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= ctip_pkg::CFG_ENTRY_COUNT;
		cfg_data  <= count;
		@(negedge clk);
		cfg_index <= ctip_pkg::CFG_MIN_TEMP;
		cfg_data  <= cutoff;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Query temperature mostly inside a bracket of the live rows, sometimes at the edges.
	function automatic logic [31:0] pick_temperature();
		int unsigned k, sel;
		logic [31:0] a, b;
		sel = $urandom_range(99);
		k = $urandom_range(live_rows - 2);
		a = row_temp[k];
		b = row_temp[k + 1];
		if (a > b) begin
			a = row_temp[k + 1];
			b = row_temp[k];
		end
		if (sel < 70) return $urandom_range(b, a);
		if (sel < 80) return row_temp[$urandom_range(live_rows - 1)];
		if (sel < 87) return $urandom;
		if (sel < 93) return (row_temp[0] == 0) ? 32'd0 : $urandom_range(row_temp[0] - 1);
		if (row_temp[live_rows - 1] == 32'hFFFF_FFFF) return 32'hFFFF_FFFF;
		return $urandom_range(32'hFFFF_FFFF, row_temp[live_rows - 1] + 1);
	endfunction

	initial begin
		int unsigned counts [8];
		logic [31:0] acc, cutoff;
		int unsigned sel;
		counts = '{1024, 3, 0, 2047, 17, 1, 1024, 200};
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = ctip_pkg::CFG_ENTRY_COUNT;
		cfg_data      = '0;
		items_sent    = 0;
		send_idle_pct = 34;
		recv_idle_pct = 61;
		item_in.valid               = 1'b0;
		item_in.opcode              = ctip_pkg::OP_WRITE;
		item_in.row_index           = '0;
		item_in.row_temperature     = '0;
		item_in.row_rate_primordial = '0;
		item_in.row_rate_metal      = '0;
		item_in.temperature         = '0;
		item_in.metallicity         = '0;
		result_out.ready            = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part on a two-row table with extreme rates.
		set_registers(2, 0);
		live_rows = 2;
		write_row(0, 100, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		write_row(1, 200, 0, 32'hFFFF_FFFF);
		query(50, 16'hFFFF);
		query(0, 16'h1000);
		query(300, 16'hFFFF);
		query(32'hFFFF_FFFF, 16'h0000);
		query(150, 16'hFFFF);
		query(100, 16'h0000);
		query(200, 16'hFFFF);
		query(199, 16'h0001);
		// Equal temperatures in the bracket give the lower row's rate.
		write_row(1, 100, 32'h1234_5678, 32'h0000_0001);
		query(100, 16'h8000);
		write_row(0, 0, 0, 0);
		write_row(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		query(32'h8000_0000, 16'hFFFF);
		query(32'hFFFF_FFFE, 16'hFFFF);
		// Cutoff at its extremes and just at the threshold.
		set_registers(2, 32'hFFFF_FFFF);
		query(32'hFFFF_FFFE, 16'hFFFF);
		query(32'hFFFF_FFFF, 16'hFFFF);
		set_registers(2, 500);
		query(499, 16'h1000);
		query(500, 16'h1000);

		// Fill the whole table with rising temperatures.
		acc = $urandom_range(1000);
		for (int i = 0; i < 1024; i++) begin
			write_row(10'(i), acc, $urandom, $urandom);
			acc += $urandom_range(4000000, 1);
		end

		// Random phases over several row counts and cutoffs.
		for (int p = 0; p < 8; p++) begin
			live_rows = (counts[p] < 2) ? 2 : (counts[p] > 1024 ? 1024 : counts[p]);
			sel = $urandom_range(2);
			if (sel == 0) cutoff = 0;
			else cutoff = row_temp[$urandom_range(live_rows - 1)];
			set_registers(counts[p], cutoff);
			for (int j = 0; j < 85; j++) begin
				sel = $urandom_range(99);
				if (sel < 8) begin
					// Row rewrite with the temperature of another live row or, sometimes, a random one; either can break the order.
					write_row(10'($urandom_range(live_rows - 1)),
						($urandom_range(3) == 0) ? $urandom : row_temp[$urandom_range(live_rows - 1)],
						$urandom, $urandom);
				end else begin
					query(pick_temperature(), 16'($urandom));
				end
			end
		end

		item_in.valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

// ===== files.f =====
hdl/ctip_pkg.sv
hdl/ctip_if.sv
hdl/ctip_ram.sv
hdl/ctip_front.sv
hdl/ctip_back.sv
hdl/cooling_table_interpolator_core.sv
hdl/ctip_checker.sv
dv/cooling_table_interpolator_checker.sv
dv/cooling_table_interpolator_core_tb.sv
